/* rtl/nearest_sampler_address_gen_top_defines.svh */
// Assertion macros for the nearest sampler address generator.
// Included by the top level; no other dependencies.
`ifndef NEAREST_SAMPLER_ADDRESS_GEN_TOP_DEFINES_SVH
`define NEAREST_SAMPLER_ADDRESS_GEN_TOP_DEFINES_SVH

// Property that must hold in the same cycle as its antecedent.
`define NSAG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Property that must hold in the cycle after its antecedent.
`define NSAG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/nsag_pkg.sv */
// Shared widths, register codes, stage types and a helper function for the
// nearest sampler address generator. No dependencies.
`timescale 1ns / 1ps

package nsag_pkg;

    localparam int COORD_W        = 32;
    localparam int PIX_W          = 13;
    localparam int STRIDE_W       = 18;
    localparam int IDX_W          = 24;
    localparam int OFS_W          = 30;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 18;
    localparam int FRAC_BITS_DEF  = 16;

    localparam logic [PIX_W-1:0]    WIDTH_RST  = PIX_W'(1);
    localparam logic [PIX_W-1:0]    HEIGHT_RST = PIX_W'(1);
    localparam logic [STRIDE_W-1:0] STRIDE_RST = '0;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_STRIDE = 2'd2
    } t_cfg_reg;

    // Fixed-point coordinates of one pixel, leaving the accumulator stage.
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [IDX_W-1:0]          dest;
        logic                      last;
    } t_coord_stage;

    // Integer pixel position, leaving the clamp and round stage.
    typedef struct packed {
        logic [PIX_W-1:0] x;
        logic [PIX_W-1:0] y;
        logic [IDX_W-1:0] dest;
        logic             last;
    } t_pix_stage;

    // Signed add that saturates to the 32-bit range.
    function automatic logic signed [COORD_W-1:0] sat_add(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [COORD_W:0] sum;
        logic signed [COORD_W-1:0] res;
        sum = {a[COORD_W-1], a} + {b[COORD_W-1], b};
        if (sum[COORD_W] != sum[COORD_W-1]) begin
            res = sum[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end else begin
            res = sum[COORD_W-1:0];
        end
        return res;
    endfunction

endpackage

/* rtl/nsag_if.sv */
// Handshake interfaces for the pixel request channel and the address result
// channel. Depends on nsag_pkg for field widths.
`timescale 1ns / 1ps

interface nsag_in_if import nsag_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      first;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] step_x;
    logic signed [COORD_W-1:0] step_y;
    logic [IDX_W-1:0]          start_index;
    logic                      last_pixel;

    modport source (
        output valid, first, start_x, start_y, step_x, step_y, start_index, last_pixel,
        input  ready
    );
    modport sink (
        input  valid, first, start_x, start_y, step_x, step_y, start_index, last_pixel,
        output ready
    );
endinterface

interface nsag_out_if import nsag_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OFS_W-1:0] source_offset;
    logic [IDX_W-1:0] dest_index;
    logic             end_of_run;

    modport source (
        output valid, source_offset, dest_index, end_of_run,
        input  ready
    );
    modport sink (
        input  valid, source_offset, dest_index, end_of_run,
        output ready
    );
endinterface

/* rtl/nsag_accum.sv */
// Input stage: holds the coordinate accumulators, steps and destination index,
// and registers the coordinates of each accepted pixel. Depends on nsag_pkg.
`timescale 1ns / 1ps

module nsag_accum import nsag_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    nsag_in_if.sink       i_pix,
    output logic          o_valid,
    input  logic          i_ready,
    output t_coord_stage  o_stage
);

    logic signed [COORD_W-1:0] r_cur_x, r_cur_y, r_inc_x, r_inc_y;
    logic [IDX_W-1:0]          r_next_dest;
    logic                      r_valid;
    t_coord_stage              r_stage;

    logic                      w_en, w_accept;
    logic signed [COORD_W-1:0] w_base_x, w_base_y, w_base_inc_x, w_base_inc_y;
    logic [IDX_W-1:0]          w_base_dest;

    // The stage moves when it is empty or the next stage takes its contents.
    assign w_en        = !r_valid || i_ready;
    assign i_pix.ready = w_en;
    assign w_accept    = i_pix.valid && w_en;

    // A first pixel of a run replaces the running state before it is used.
    always_comb begin
        if (i_pix.first) begin
            w_base_x     = i_pix.start_x;
            w_base_y     = i_pix.start_y;
            w_base_inc_x = i_pix.step_x;
            w_base_inc_y = i_pix.step_y;
            w_base_dest  = i_pix.start_index;
        end else begin
            w_base_x     = r_cur_x;
            w_base_y     = r_cur_y;
            w_base_inc_x = r_inc_x;
            w_base_inc_y = r_inc_y;
            w_base_dest  = r_next_dest;
        end
    end

    // Accumulators advance once per accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_inc_x     <= '0;
            r_inc_y     <= '0;
            r_next_dest <= '0;
        end else if (w_accept) begin
            r_cur_x     <= sat_add(w_base_x, w_base_inc_x);
            r_cur_y     <= sat_add(w_base_y, w_base_inc_y);
            r_inc_x     <= w_base_inc_x;
            r_inc_y     <= w_base_inc_y;
            r_next_dest <= w_base_dest + IDX_W'(1);
        end
    end

    // Stage valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_pix.valid;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_stage.x    <= w_base_x;
            r_stage.y    <= w_base_y;
            r_stage.dest <= w_base_dest;
            r_stage.last <= i_pix.last_pixel;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

/* rtl/nsag_pixel.sv */
// Clamp and round stage: turns fixed-point coordinates into integer pixel
// positions inside the image. Depends on nsag_pkg.
`timescale 1ns / 1ps

module nsag_pixel import nsag_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [PIX_W-1:0] i_width,
    input  logic [PIX_W-1:0] i_height,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_coord_stage     i_stage,
    output logic             o_valid,
    input  logic             i_ready,
    output t_pix_stage       o_stage
);

    localparam int FIX_W = ((COORD_W > PIX_W + FRAC_BITS) ? COORD_W : PIX_W + FRAC_BITS) + 1;

    logic       r_valid;
    t_pix_stage r_stage;
    logic       w_en;

    // Clamp to [0, size-1] in fixed point, then add one half and drop the fraction.
    function automatic logic [PIX_W-1:0] pick(
        input logic signed [COORD_W-1:0] coord,
        input logic [PIX_W-1:0]          size
    );
        logic [PIX_W-1:0] limit;
        logic [FIX_W-1:0] maxfix;
        logic [FIX_W-1:0] mag;
        logic [FIX_W-1:0] v;
        logic [FIX_W-1:0] rnd;
        limit  = (size == '0) ? '0 : size - PIX_W'(1);
        maxfix = FIX_W'(limit) << FRAC_BITS;
        mag    = FIX_W'(coord[COORD_W-2:0]);
        if (coord[COORD_W-1]) begin
            v = '0;
        end else if (mag > maxfix) begin
            v = maxfix;
        end else begin
            v = mag;
        end
        rnd = v + (FIX_W'(1) << (FRAC_BITS - 1));
        return PIX_W'(rnd >> FRAC_BITS);
    endfunction

    assign w_en    = !r_valid || i_ready;
    assign o_ready = w_en;

    // Stage valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_valid;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (w_en && i_valid) begin
            r_stage.x    <= pick(i_stage.x, i_width);
            r_stage.y    <= pick(i_stage.y, i_height);
            r_stage.dest <= i_stage.dest;
            r_stage.last <= i_stage.last;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

/* rtl/nsag_offset.sv */
// Output stage: forms the source byte offset y*row_stride + 4*x and holds the
// result transaction until it is taken. Depends on nsag_pkg and nsag_out_if.
`timescale 1ns / 1ps

module nsag_offset import nsag_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [STRIDE_W-1:0] i_stride,
    input  logic                i_valid,
    output logic                o_ready,
    input  t_pix_stage          i_stage,
    nsag_out_if.source          o_addr
);

    logic                      r_valid;
    logic [OFS_W-1:0]          r_ofs;
    logic [IDX_W-1:0]          r_dest;
    logic                      r_last;
    logic                      w_en;
    logic [PIX_W+STRIDE_W-1:0] w_row;
    logic [PIX_W+STRIDE_W-1:0] w_sum;

    assign w_en    = !r_valid || o_addr.ready;
    assign o_ready = w_en;

    // Row base plus column byte offset; the sum wraps to the offset width.
    assign w_row = (PIX_W + STRIDE_W)'(i_stage.y) * (PIX_W + STRIDE_W)'(i_stride);
    assign w_sum = w_row + (PIX_W + STRIDE_W)'({i_stage.x, 2'b00});

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_valid;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (w_en && i_valid) begin
            r_ofs  <= OFS_W'(w_sum);
            r_dest <= i_stage.dest;
            r_last <= i_stage.last;
        end
    end

    assign o_addr.valid         = r_valid;
    assign o_addr.source_offset = r_ofs;
    assign o_addr.dest_index    = r_dest;
    assign o_addr.end_of_run    = r_last;

endmodule

/* rtl/nearest_sampler_address_gen_top.sv */
// Top level of the nearest sampler address generator: configuration registers
// and the three pipeline stages. Depends on nsag_pkg, nsag_if and the defines header.
//
// Usage: i_pix carries one transaction per destination pixel. A transaction
// with first set loads the start point, the per-pixel steps (signed fixed point)
// and the start index before that pixel is used. o_addr returns one transaction
// per pixel: the source byte offset, the destination index and end_of_run.
// Width, height and row stride are written through i_cfg_we / i_cfg_idx /
// i_cfg_data while the block is idle.
// Throughput is one pixel per cycle while results are taken; the saturating
// accumulator add in the input stage is the only loop-carried path. A result
// passes three register stages (accumulator, clamp and round, offset) on its
// way from request to output.
// Reset clears the accumulators, steps and index to zero and sets width and
// height to one and the stride to zero. When the receiver stalls, the result
// holds and the pipeline keeps filling; i_pix.ready drops only once all three
// stages hold pixels.
`timescale 1ns / 1ps
`include "nearest_sampler_address_gen_top_defines.svh"

module nearest_sampler_address_gen_top import nsag_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    nsag_in_if.sink               i_pix,
    nsag_out_if.source            o_addr
);

    logic [PIX_W-1:0]    r_width, r_height;
    logic [STRIDE_W-1:0] r_stride;

    logic         w_coord_valid, w_coord_ready;
    t_coord_stage w_coord;
    logic         w_pix_valid, w_pix_ready;
    t_pix_stage   w_pix;

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
            r_stride <= STRIDE_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                CFG_WIDTH:  r_width  <= PIX_W'(i_cfg_data);
                CFG_HEIGHT: r_height <= PIX_W'(i_cfg_data);
                CFG_STRIDE: r_stride <= i_cfg_data;
                default: ;
            endcase
        end
    end

    nsag_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (i_pix),
        .o_valid (w_coord_valid),
        .i_ready (w_coord_ready),
        .o_stage (w_coord)
    );

    nsag_pixel #(
        .FRAC_BITS (FRAC_BITS)
    ) u_pixel (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_width  (r_width),
        .i_height (r_height),
        .i_valid  (w_coord_valid),
        .o_ready  (w_coord_ready),
        .i_stage  (w_coord),
        .o_valid  (w_pix_valid),
        .i_ready  (w_pix_ready),
        .o_stage  (w_pix)
    );

    nsag_offset u_offset (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_stride (r_stride),
        .i_valid  (w_pix_valid),
        .o_ready  (w_pix_ready),
        .i_stage  (w_pix),
        .o_addr   (o_addr)
    );

    // A first pixel enters the pipeline with its own start point and index.
    `NSAG_ASSERT_NEXT(first_loads_start, i_clk, i_rst_n, i_pix.valid && i_pix.ready && i_pix.first, (w_coord.dest == $past(i_pix.start_index)) && (w_coord.x == $past(i_pix.start_x)), "first pixel did not load its start point")

    // Input backpressure appears only when every stage is occupied and stalled.
    `NSAG_ASSERT_NOW(full_pipe_stalls, i_clk, i_rst_n, !i_pix.ready, o_addr.valid && !o_addr.ready && w_pix_valid && w_coord_valid, "input stalled with room in the pipeline")

    // A pixel moving into the output stage shows up with its destination index.
    `NSAG_ASSERT_NEXT(pix_reaches_output, i_clk, i_rst_n, w_pix_valid && w_pix_ready, o_addr.valid && (o_addr.dest_index == $past(w_pix.dest)), "pixel lost on its way to the output")

endmodule

/* tb/nearest_sampler_address_gen_top_tb.sv */
// Self-checking testbench for the nearest sampler address generator.
// Depends on nsag_pkg, the nsag_in_if / nsag_out_if interfaces and the top level.
`timescale 1ns / 1ps

module nearest_sampler_address_gen_top_tb;
    import nsag_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam int RANDOM_PHASES = 6;
    localparam int ITEMS_PER_PHASE = 115;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;
    localparam longint COORD_MAX = 64'sd2147483647;
    localparam longint COORD_MIN = -64'sd2147483648;
    // Index with no register behind it; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // One pixel request as the sender presents it.
    typedef struct {
        logic                      first;
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] step_x;
        logic signed [COORD_W-1:0] step_y;
        logic [IDX_W-1:0]          start_index;
        logic                      last_pixel;
    } t_pixel_req;

    // One address result as the block returns it.
    typedef struct {
        logic [OFS_W-1:0] source_offset;
        logic [IDX_W-1:0] dest_index;
        logic             end_of_run;
    } t_addr_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    nsag_in_if  pix_if ();
    nsag_out_if addr_if ();

    nearest_sampler_address_gen_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_if),
        .o_addr     (addr_if)
    );

    // Predicted register contents and walker state.
    logic [PIX_W-1:0]          img_w;
    logic [PIX_W-1:0]          img_h;
    logic [STRIDE_W-1:0]       row_bytes;
    logic signed [COORD_W-1:0] acc_x;
    logic signed [COORD_W-1:0] acc_y;
    logic signed [COORD_W-1:0] inc_x;
    logic signed [COORD_W-1:0] inc_y;
    logic [IDX_W-1:0]          dest_next;

    t_pixel_req   pix_q[$];
    t_addr_result addr_due_q[$];
    t_pixel_req   held_req;

    int queued_cnt;
    int received_cnt;
    int err_cnt;
    int cycle_cnt;
    int send_gap;
    int rcv_stall;
    int send_odds;
    int rcv_odds;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Clamp a fixed-point coordinate to [0, size-1] and round half up.
    function automatic logic [PIX_W-1:0] nearest_pixel(input logic signed [COORD_W-1:0] coord,
                                                       input logic [PIX_W-1:0] size);
        longint top;
        longint v;
        top = (size == 0) ? 64'sd0 : ((longint'(size) - 1) <<< FRAC);
        if (coord < 0) v = 0;
        else if (longint'(coord) > top) v = top;
        else v = longint'(coord);
        v = (v + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
        return v[PIX_W-1:0];
    endfunction

    function automatic logic signed [COORD_W-1:0] sat_sum(input logic signed [COORD_W-1:0] a,
                                                          input logic signed [COORD_W-1:0] b);
        longint s;
        s = longint'(a) + longint'(b);
        if (s > COORD_MAX) s = COORD_MAX;
        if (s < COORD_MIN) s = COORD_MIN;
        return s[COORD_W-1:0];
    endfunction

    // Address of the pixel that this request samples; advances the walker.
    function automatic t_addr_result next_address(input t_pixel_req r);
        t_addr_result res;
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] py;
        longint ofs;
        if (r.first) begin
            acc_x = r.start_x;
            acc_y = r.start_y;
            inc_x = r.step_x;
            inc_y = r.step_y;
            dest_next = r.start_index;
        end
        px = nearest_pixel(acc_x, img_w);
        py = nearest_pixel(acc_y, img_h);
        ofs = longint'(py) * longint'(row_bytes) + 4 * longint'(px);
        res.source_offset = ofs[OFS_W-1:0];
        res.dest_index = dest_next;
        res.end_of_run = r.last_pixel;
        acc_x = sat_sum(acc_x, inc_x);
        acc_y = sat_sum(acc_y, inc_y);
        dest_next = dest_next + 1'b1;
        return res;
    endfunction

    // Request driver: presents queued pixels, with random idle bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_if.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (pix_if.valid && pix_if.ready) begin
                addr_due_q.push_back(next_address(held_req));
            end
            if (!pix_if.valid || pix_if.ready) begin
                if (send_gap == 0 && send_odds != 0 && $urandom_range(0, 99) < send_odds) begin
                    send_gap = $urandom_range(1, 18);
                end
                if (send_gap > 0) begin
                    send_gap--;
                    pix_if.valid <= 1'b0;
                end else if (pix_q.size() != 0) begin
                    held_req = pix_q.pop_front();
                    pix_if.first       <= held_req.first;
                    pix_if.start_x     <= held_req.start_x;
                    pix_if.start_y     <= held_req.start_y;
                    pix_if.step_x      <= held_req.step_x;
                    pix_if.step_y      <= held_req.step_y;
                    pix_if.start_index <= held_req.start_index;
                    pix_if.last_pixel  <= held_req.last_pixel;
                    pix_if.valid       <= 1'b1;
                end else begin
                    pix_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each transaction against the oldest prediction.
    always @(posedge i_clk) begin
        t_addr_result want;
        if (!i_rst_n) begin
            addr_if.ready <= 1'b0;
            rcv_stall = 0;
        end else begin
            if (addr_if.valid && addr_if.ready) begin
                received_cnt++;
                if (addr_due_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS) begin
                        $display("unexpected result: offset %0d dest %0d end %0b",
                                 addr_if.source_offset, addr_if.dest_index, addr_if.end_of_run);
                    end
                end else begin
                    want = addr_due_q.pop_front();
                    if (addr_if.source_offset !== want.source_offset
                        || addr_if.dest_index !== want.dest_index
                        || addr_if.end_of_run !== want.end_of_run) begin
                        err_cnt++;
                        if (err_cnt <= MAX_REPORTS) begin
                            $display("mismatch (exp/got): offset %0d/%0d dest %0d/%0d end %0b/%0b",
                                     want.source_offset, addr_if.source_offset,
                                     want.dest_index, addr_if.dest_index,
                                     want.end_of_run, addr_if.end_of_run);
                        end
                    end
                end
            end
            if (rcv_stall == 0 && rcv_odds != 0 && $urandom_range(0, 99) < rcv_odds) begin
                rcv_stall = $urandom_range(1, 18);
            end
            if (rcv_stall > 0) begin
                rcv_stall--;
                addr_if.ready <= 1'b0;
            end else begin
                addr_if.ready <= 1'b1;
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic void queue_req(input t_pixel_req r);
        pix_q.push_back(r);
        queued_cnt++;
    endfunction

    function automatic void queue_start(input int sx, input int sy, input int dx, input int dy,
                                        input logic [IDX_W-1:0] idx, input logic last);
        t_pixel_req r;
        r.first = 1'b1;
        r.start_x = sx;
        r.start_y = sy;
        r.step_x = dx;
        r.step_y = dy;
        r.start_index = idx;
        r.last_pixel = last;
        queue_req(r);
    endfunction

    // Continuation pixel; the load fields carry junk that must be ignored.
    function automatic void queue_next(input logic last);
        t_pixel_req r;
        r.first = 1'b0;
        r.start_x = $urandom;
        r.start_y = $urandom;
        r.step_x = $urandom;
        r.step_y = $urandom;
        r.start_index = IDX_W'($urandom);
        r.last_pixel = last;
        queue_req(r);
    endfunction

    // Fully random request, including wild starts and steps.
    function automatic void queue_noise();
        t_pixel_req r;
        r.first = 1'($urandom_range(0, 1));
        r.start_x = $urandom;
        r.start_y = $urandom;
        r.step_x = $urandom;
        r.step_y = $urandom;
        r.start_index = IDX_W'($urandom);
        r.last_pixel = 1'($urandom_range(0, 1));
        queue_req(r);
    endfunction

    function automatic int random_step();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return int'($urandom);
            default: return int'($urandom_range(0, 4 << FRAC)) - (2 << FRAC);
        endcase
    endfunction

    // A run of pixels starting near the image; one in eight is malformed.
    function automatic void queue_run();
        int len;
        int sx;
        int sy;
        int dx;
        int dy;
        bit broken;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
        sx = int'($urandom_range(0, (int'(img_w) + 4) << FRAC)) - (2 << FRAC);
        sy = int'($urandom_range(0, (int'(img_h) + 4) << FRAC)) - (2 << FRAC);
        dx = random_step();
        dy = random_step();
        broken = ($urandom_range(0, 7) == 0);
        queue_start(sx, sy, dx, dy, IDX_W'($urandom), (len == 1) && !broken);
        for (int i = 1; i < len; i++) begin
            queue_next(broken ? 1'($urandom_range(0, 1)) : (i == len - 1));
        end
    endfunction

    // Wait for every transaction to return, then for the pipeline to go quiet.
    task automatic settle();
        do @(posedge i_clk); while (received_cnt != queued_cnt);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_WIDTH:  img_w = data[PIX_W-1:0];
            CFG_HEIGHT: img_h = data[PIX_W-1:0];
            CFG_STRIDE: row_bytes = data[STRIDE_W-1:0];
            default:    ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [CFG_DATA_W-1:0] random_size();
        case ($urandom_range(0, 7))
            0: return CFG_DATA_W'(1);
            1: return CFG_DATA_W'(4096);
            2: return CFG_DATA_W'(8191);
            3: return CFG_DATA_W'($urandom_range(1, 16));
            default: return CFG_DATA_W'($urandom_range(1, 4096));
        endcase
    endfunction

    task automatic random_setup();
        write_reg(CFG_WIDTH, random_size());
        write_reg(CFG_HEIGHT, random_size());
        case ($urandom_range(0, 3))
            0: write_reg(CFG_STRIDE, CFG_DATA_W'(4 * img_w));
            1: write_reg(CFG_STRIDE, CFG_DATA_W'(262143));
            default: write_reg(CFG_STRIDE, CFG_DATA_W'($urandom_range(0, 262143)));
        endcase
    endtask

    initial begin
        int target;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_WIDTH;
        i_cfg_data = '0;
        pix_if.valid = 1'b0;
        pix_if.first = 1'b0;
        pix_if.start_x = '0;
        pix_if.start_y = '0;
        pix_if.step_x = '0;
        pix_if.step_y = '0;
        pix_if.start_index = '0;
        pix_if.last_pixel = 1'b0;
        addr_if.ready = 1'b0;
        img_w = WIDTH_RST;
        img_h = HEIGHT_RST;
        row_bytes = STRIDE_RST;
        acc_x = '0;
        acc_y = '0;
        inc_x = '0;
        inc_y = '0;
        dest_next = '0;
        queued_cnt = 0;
        received_cnt = 0;
        err_cnt = 0;
        cycle_cnt = 0;
        send_odds = 10;
        rcv_odds = 10;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Pixels before any run start use the reset walker and registers.
        queue_next(1'b0);
        queue_next(1'b1);
        settle();

        // Small image: half-up rounding, clamping, saturation and index wrap.
        write_reg(CFG_WIDTH, CFG_DATA_W'(64));
        write_reg(CFG_HEIGHT, CFG_DATA_W'(48));
        write_reg(CFG_STRIDE, CFG_DATA_W'(256));
        queue_start(0, 0, 1 << FRAC, 1 << (FRAC - 1), 24'h000000, 1'b0);
        queue_next(1'b0);
        queue_next(1'b1);
        queue_start(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    24'hFFFFFE, 1'b0);
        queue_next(1'b0);
        queue_next(1'b1);
        queue_start(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    24'h5A5A5A, 1'b0);
        queue_next(1'b1);
        queue_start((10 << FRAC) + (1 << (FRAC - 1)), (5 << FRAC) + (1 << (FRAC - 1)) - 1,
                    -1, 1 << (FRAC - 1), 24'hFFFFFF, 1'b0);
        queue_next(1'b1);
        queue_start((63 << FRAC) + (1 << (FRAC - 1)), (47 << FRAC) + 1, -(64 << FRAC), 0,
                    24'h123456, 1'b1);
        settle();

        // Largest sizes: the byte offset runs past 30 bits and wraps.
        write_reg(CFG_WIDTH, CFG_DATA_W'(8191));
        write_reg(CFG_HEIGHT, CFG_DATA_W'(8191));
        write_reg(CFG_STRIDE, CFG_DATA_W'(262143));
        queue_start(8190 << FRAC, 8190 << FRAC, 0, 0, 24'h000010, 1'b0);
        queue_next(1'b0);
        queue_next(1'b1);
        queue_start(4095 << FRAC, 4096 << FRAC, 1 << FRAC, -(1 << FRAC), 24'h800000, 1'b1);
        settle();

        // Zero sizes after truncation of the wide write data, and a write to
        // the unused index that must leave everything alone.
        write_reg(CFG_WIDTH, 18'h3E000);
        write_reg(CFG_HEIGHT, 18'h02000);
        write_reg(CFG_STRIDE, 18'h00400);
        write_reg(CFG_UNUSED, 18'h3FFFF);
        queue_start((5 << FRAC) + 16'hB333, (3 << FRAC) + 16'h3333, 1 << FRAC, 1 << FRAC,
                    24'h00ABCD, 1'b0);
        queue_next(1'b0);
        queue_next(1'b1);
        settle();

        // Random phases, each under a fresh register setting; the last one
        // runs with both sides always willing.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            random_setup();
            send_odds = (ph == RANDOM_PHASES - 1 || ph == 1) ? 0 : $urandom_range(3, 25);
            rcv_odds = (ph == RANDOM_PHASES - 1 || ph == 2) ? 0 : $urandom_range(3, 25);
            target = queued_cnt + ITEMS_PER_PHASE;
            while (queued_cnt < target) begin
                if ($urandom_range(0, 4) == 0) queue_noise();
                else queue_run();
            end
            settle();
        end

        repeat (10) @(posedge i_clk);
        if (addr_due_q.size() != 0) err_cnt++;
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/nsag_pkg.sv
rtl/nsag_if.sv
rtl/nsag_accum.sv
rtl/nsag_pixel.sv
rtl/nsag_offset.sv
rtl/nearest_sampler_address_gen_top.sv
tb/nearest_sampler_address_gen_top_tb.sv
